// ===== src/rmeo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmeo_pkg
// Shared constants, register indexes and the lane result type of the rail monitor.
// ----------------------------------------------------------------------------
package rmeo_pkg;

    localparam int RAIL_COUNT            = 5;
    localparam int SUM_COUNT             = 2 * RAIL_COUNT + 1;
    localparam int AVERAGE_SHIFT_DEFAULT = 3;
    localparam int SAMPLE_W              = 16;
    localparam int POWER_W               = 2 * SAMPLE_W;
    localparam int CFG_INDEX_W           = 3;
    localparam int CFG_DATA_W            = 32;

    localparam logic [SAMPLE_W-1:0]    LIMIT_RESET = 16'hFFFF;
    localparam logic [POWER_W-1:0]     POWER_RESET = 32'd94500000;
    localparam logic [SAMPLE_W-1:0]    SEED_OFFSET = 16'd100;

    // register map: current limits sit at 0 .. RAIL_COUNT-1
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_LIMIT = CFG_INDEX_W'(RAIL_COUNT);

    typedef struct packed {
        logic [POWER_W-1:0] product;
        logic               amp_trip;
    } lane_result_t;

endpackage

// ===== src/rmeo_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmeo_cfg
// Limit registers: per-rail current limits and the shared power limit.
// ----------------------------------------------------------------------------
module rmeo_cfg
    import rmeo_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [SAMPLE_W-1:0]    current_limit [RAIL_COUNT],
    output logic [POWER_W-1:0]     power_limit
);

    logic [SAMPLE_W-1:0] limit_reg [RAIL_COUNT];
    logic [POWER_W-1:0]  power_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RAIL_COUNT; k++)
            begin
                limit_reg[k] <= LIMIT_RESET;
            end
            power_reg <= POWER_RESET;
        end
        else if (cfg_valid)
        begin
            for (int k = 0; k < RAIL_COUNT; k++)
            begin
                if (cfg_index == CFG_INDEX_W'(k))
                begin
                    limit_reg[k] <= cfg_data[SAMPLE_W-1:0];
                end
            end
            // indexes past the map are dropped
            if (cfg_index == REG_POWER_LIMIT)
            begin
                power_reg <= cfg_data[POWER_W-1:0];
            end
        end
    end

    assign current_limit = limit_reg;
    assign power_limit   = power_reg;

endmodule

// ===== src/rmeo_ema.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmeo_ema
// One running sum: seed, EMA update, registered average.
// ----------------------------------------------------------------------------
module rmeo_ema
    import rmeo_pkg::*;
#(
    parameter int AVERAGE_SHIFT = AVERAGE_SHIFT_DEFAULT,
    parameter bit IS_CURRENT    = 1'b0
)
(
    input  logic                clk,
    input  logic                seed,
    input  logic                update,
    input  logic [SAMPLE_W-1:0] sample,
    output logic [SAMPLE_W-1:0] average
);

    localparam int SUM_W = SAMPLE_W + AVERAGE_SHIFT;

    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W:0]      sum_wide;
    logic [SAMPLE_W-1:0] seed_val;
    logic [SAMPLE_W-1:0] avg_reg;

    always_comb
    begin
        // currents are seeded with the zero offset removed
        if (IS_CURRENT)
        begin
            seed_val = (sample > SEED_OFFSET) ? sample - SEED_OFFSET : '0;
        end
        else
        begin
            seed_val = sample;
        end
        sum_wide = {1'b0, sum_reg} - ({1'b0, sum_reg} >> AVERAGE_SHIFT)
                 + {{(AVERAGE_SHIFT + 1){1'b0}}, sample};
        sum_next = sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (seed)
        begin
            sum_reg <= {seed_val, {AVERAGE_SHIFT{1'b0}}};
        end
        else if (update)
        begin
            sum_reg <= sum_next;
            avg_reg <= sum_next[SUM_W-1:AVERAGE_SHIFT];
        end
    end

    assign average = avg_reg;

endmodule

// ===== src/rmeo_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmeo_lane
// One rail: voltage and current averages, V*I product, fast current trip.
// ----------------------------------------------------------------------------
module rmeo_lane
    import rmeo_pkg::*;
#(
    parameter int AVERAGE_SHIFT = AVERAGE_SHIFT_DEFAULT
)
(
    input  logic                clk,
    input  logic                seed,
    input  logic                update,
    input  logic [SAMPLE_W-1:0] volts,
    input  logic [SAMPLE_W-1:0] amps,
    input  logic [SAMPLE_W-1:0] current_limit,
    output logic [SAMPLE_W-1:0] avg_volts,
    output logic [SAMPLE_W-1:0] avg_amps,
    output lane_result_t        result
);

    lane_result_t result_reg;

    rmeo_ema #(
        .AVERAGE_SHIFT (AVERAGE_SHIFT),
        .IS_CURRENT    (1'b0)
    ) u_volts (
        .clk     (clk),
        .seed    (seed),
        .update  (update),
        .sample  (volts),
        .average (avg_volts)
    );

    rmeo_ema #(
        .AVERAGE_SHIFT (AVERAGE_SHIFT),
        .IS_CURRENT    (1'b1)
    ) u_amps (
        .clk     (clk),
        .seed    (seed),
        .update  (update),
        .sample  (amps),
        .average (avg_amps)
    );

    // product compare happens in the merge stage, after this register
    always_ff @(posedge clk)
    begin
        if (update)
        begin
            result_reg.product  <= POWER_W'(volts) * POWER_W'(amps);
            result_reg.amp_trip <= (amps > current_limit);
        end
    end

    assign result = result_reg;

endmodule

// ===== src/rmeo_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmeo_merge
// Combines lane trip flags into the enable mask; holds the output beat.
// ----------------------------------------------------------------------------
module rmeo_merge
    import rmeo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s1_valid,
    input  logic [RAIL_COUNT-1:0] s1_mask,
    input  lane_result_t          lane_res [RAIL_COUNT],
    input  logic [SAMPLE_W-1:0]   s1_avg [SUM_COUNT],
    input  logic [POWER_W-1:0]    power_limit,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [RAIL_COUNT-1:0] mask_out,
    output logic [SAMPLE_W-1:0]   avg_out [SUM_COUNT]
);

    logic                  valid_reg;
    logic [RAIL_COUNT-1:0] mask_reg;
    logic [SAMPLE_W-1:0]   avg_reg [SUM_COUNT];
    logic [RAIL_COUNT-1:0] trip;
    logic                  load;

    assign load = !valid_reg || out_ready;

    always_comb
    begin
        for (int k = 0; k < RAIL_COUNT; k++)
        begin
            trip[k] = lane_res[k].amp_trip || (lane_res[k].product > power_limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && s1_valid)
        begin
            mask_reg <= s1_mask & ~trip;
            avg_reg  <= s1_avg;
        end
    end

    assign out_valid = valid_reg;
    assign mask_out  = mask_reg;
    assign avg_out   = avg_reg;

endmodule

// ===== src/rail_monitor_ema_overcurrent_trip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rail_monitor_ema_overcurrent_trip
// Five rail lanes plus temperature EMA; trips rails on current or V*I.
// Pipeline: an accepted sample beat passes the lane stage with the 16x16 product,
// then the trip compare and output register, before its result beat is valid.
// Throughput: one sample beat per cycle; in_ready drops only while the output
// beat is held by out_ready low. The first beat after reset seeds the sums
// and yields no result. Reset clears the seeded flag and valids and returns
// the limits to their reset values; sums need no reset.
// ----------------------------------------------------------------------------
module rail_monitor_ema_overcurrent_trip
    import rmeo_pkg::*;
#(
    parameter int AVERAGE_SHIFT = AVERAGE_SHIFT_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_W-1:0]    rail1_volts,
    input  logic [SAMPLE_W-1:0]    rail1_amps,
    input  logic [SAMPLE_W-1:0]    rail2_volts,
    input  logic [SAMPLE_W-1:0]    rail2_amps,
    input  logic [SAMPLE_W-1:0]    rail3_volts,
    input  logic [SAMPLE_W-1:0]    rail3_amps,
    input  logic [SAMPLE_W-1:0]    rail4_volts,
    input  logic [SAMPLE_W-1:0]    rail4_amps,
    input  logic [SAMPLE_W-1:0]    rail5_volts,
    input  logic [SAMPLE_W-1:0]    rail5_amps,
    input  logic [SAMPLE_W-1:0]    temp_sample,
    input  logic [RAIL_COUNT-1:0]  enable_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [RAIL_COUNT-1:0]  enable_out,
    output logic [SAMPLE_W-1:0]    avg1_volts,
    output logic [SAMPLE_W-1:0]    avg1_amps,
    output logic [SAMPLE_W-1:0]    avg2_volts,
    output logic [SAMPLE_W-1:0]    avg2_amps,
    output logic [SAMPLE_W-1:0]    avg3_volts,
    output logic [SAMPLE_W-1:0]    avg3_amps,
    output logic [SAMPLE_W-1:0]    avg4_volts,
    output logic [SAMPLE_W-1:0]    avg4_amps,
    output logic [SAMPLE_W-1:0]    avg5_volts,
    output logic [SAMPLE_W-1:0]    avg5_amps,
    output logic [SAMPLE_W-1:0]    avg_temp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [SAMPLE_W-1:0]   volts [RAIL_COUNT];
    logic [SAMPLE_W-1:0]   amps  [RAIL_COUNT];
    logic [SAMPLE_W-1:0]   current_limit [RAIL_COUNT];
    logic [POWER_W-1:0]    power_limit;
    lane_result_t          lane_res [RAIL_COUNT];
    logic [SAMPLE_W-1:0]   s1_avg  [SUM_COUNT];
    logic [SAMPLE_W-1:0]   avg_out [SUM_COUNT];

    logic                  seeded_reg;
    logic                  s1_valid_reg;
    logic [RAIL_COUNT-1:0] mask_reg;
    logic                  advance;
    logic                  accept;
    logic                  seed;
    logic                  update;

    assign volts[0] = rail1_volts;
    assign volts[1] = rail2_volts;
    assign volts[2] = rail3_volts;
    assign volts[3] = rail4_volts;
    assign volts[4] = rail5_volts;
    assign amps[0]  = rail1_amps;
    assign amps[1]  = rail2_amps;
    assign amps[2]  = rail3_amps;
    assign amps[3]  = rail4_amps;
    assign amps[4]  = rail5_amps;

    // whole pipe moves when the output register is free or being drained
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;
    assign seed     = accept && !seeded_reg;
    assign update   = accept && seeded_reg;

    rmeo_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .current_limit (current_limit),
        .power_limit   (power_limit)
    );

    for (genvar k = 0; k < RAIL_COUNT; k++)
    begin : g_lane
        rmeo_lane #(
            .AVERAGE_SHIFT (AVERAGE_SHIFT)
        ) u_lane (
            .clk           (clk),
            .seed          (seed),
            .update        (update),
            .volts         (volts[k]),
            .amps          (amps[k]),
            .current_limit (current_limit[k]),
            .avg_volts     (s1_avg[2*k]),
            .avg_amps      (s1_avg[2*k+1]),
            .result        (lane_res[k])
        );
    end

    rmeo_ema #(
        .AVERAGE_SHIFT (AVERAGE_SHIFT),
        .IS_CURRENT    (1'b0)
    ) u_temp (
        .clk     (clk),
        .seed    (seed),
        .update  (update),
        .sample  (temp_sample),
        .average (s1_avg[SUM_COUNT-1])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (seed)
            begin
                seeded_reg <= 1'b1;
            end
            if (advance)
            begin
                s1_valid_reg <= update;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            mask_reg <= enable_in;
        end
    end

    rmeo_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid_reg),
        .s1_mask     (mask_reg),
        .lane_res    (lane_res),
        .s1_avg      (s1_avg),
        .power_limit (power_limit),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .mask_out    (enable_out),
        .avg_out     (avg_out)
    );

    assign avg1_volts = avg_out[0];
    assign avg1_amps  = avg_out[1];
    assign avg2_volts = avg_out[2];
    assign avg2_amps  = avg_out[3];
    assign avg3_volts = avg_out[4];
    assign avg3_amps  = avg_out[5];
    assign avg4_volts = avg_out[6];
    assign avg4_amps  = avg_out[7];
    assign avg5_volts = avg_out[8];
    assign avg5_amps  = avg_out[9];
    assign avg_temp   = avg_out[10];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rail monitor. A scoreboard class mirrors the
// seeding, the per-rail current and power trips and the running averages.
// Sample beats go through directed corner cases and random beats under four limit
// settings, with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import rmeo_pkg::*;

    localparam int      EMA_SHIFT     = AVERAGE_SHIFT_DEFAULT;
    localparam int      SUM_W         = SAMPLE_W + EMA_SHIFT;
    localparam longint  SAMPLE_MAX    = (64'd1 << SAMPLE_W) - 1;
    localparam int      SETTLE_CYCLES = 6;
    localparam int      DRAIN_LIMIT   = 5000;
    localparam int      HOLD_CYCLES   = 150;
    localparam int      TIMEOUT_NS    = 2_000_000;

    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_ONE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_TWO   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_THREE = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_FOUR  = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_FIVE  = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO    = REG_POWER_LIMIT + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI    = '1;

    // level order: volts and amps per rail, then temperature
    typedef struct packed {
        logic [RAIL_COUNT-1:0]              enables;
        logic [SUM_COUNT-1:0][SAMPLE_W-1:0] level;
    } sample_set_t;

    typedef struct packed {
        logic [RAIL_COUNT-1:0]              enables;
        logic [SUM_COUNT-1:0][SAMPLE_W-1:0] level;
    } rail_result_t;

    class ema_trip_checker;
        logic [SAMPLE_W-1:0] amp_limit [RAIL_COUNT];
        logic [POWER_W-1:0]  power_limit;
        logic [SUM_W-1:0]    sums [SUM_COUNT];
        bit                  seeded;
        rail_result_t        expected_averages [$];
        int unsigned         averages_checked;
        int unsigned         trip_events;
        int unsigned         mismatches;

        function new();
            foreach (amp_limit[r])
                amp_limit[r] = LIMIT_RESET;
            power_limit = POWER_RESET;
            seeded = 1'b0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] data);
            if (index < REG_POWER_LIMIT)
                amp_limit[index] = data[SAMPLE_W-1:0];
            else if (index == REG_POWER_LIMIT)
                power_limit = data;
        endfunction

        function void note_sample(sample_set_t s);
            rail_result_t        want;
            logic [SAMPLE_W-1:0] level;
            logic [POWER_W-1:0]  product;
            if (!seeded)
            begin
                // currents lose the offset before seeding, floored at zero
                for (int k = 0; k < SUM_COUNT; k++)
                begin
                    level = s.level[k];
                    if (k < 2 * RAIL_COUNT && k % 2 == 1)
                        level = (level > SEED_OFFSET) ? level - SEED_OFFSET : '0;
                    sums[k] = SUM_W'(level) << EMA_SHIFT;
                end
                seeded = 1'b1;
                return;
            end
            want.enables = s.enables;
            for (int r = 0; r < RAIL_COUNT; r++)
            begin
                product = POWER_W'(s.level[2*r]) * POWER_W'(s.level[2*r+1]);
                if (s.level[2*r+1] > amp_limit[r] || product > power_limit)
                begin
                    want.enables[r] = 1'b0;
                    trip_events++;
                end
            end
            for (int k = 0; k < SUM_COUNT; k++)
            begin
                sums[k] = sums[k] - (sums[k] >> EMA_SHIFT) + SUM_W'(s.level[k]);
                want.level[k] = SAMPLE_W'(sums[k] >> EMA_SHIFT);
            end
            expected_averages.push_back(want);
        endfunction

        function void report(string msg);
            mismatches++;
            $error("%s", msg);
        endfunction

        function void flag(string field, int unsigned want, int unsigned got);
            report($sformatf("%s: expected %0d, actual %0d", field, want, got));
        endfunction

        function void check_result(rail_result_t got);
            rail_result_t want;
            string        field;
            if (expected_averages.size() == 0)
            begin
                report("result beat with no sample pending");
                return;
            end
            want = expected_averages.pop_front();
            averages_checked++;
            if (got.enables !== want.enables)
                flag("enable_out", want.enables, got.enables);
            for (int k = 0; k < SUM_COUNT; k++)
            begin
                if (got.level[k] !== want.level[k])
                begin
                    if (k == SUM_COUNT - 1)
                        field = "avg_temp";
                    else
                        field = $sformatf("avg%0d_%s", k / 2 + 1, (k % 2) ? "amps" : "volts");
                    flag(field, want.level[k], got.level[k]);
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    sample_set_t            sample_beat;
    logic                   out_valid;
    logic                   out_ready;
    wire rail_result_t      result_beat;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ema_trip_checker sb = new();
    bit              quiet;
    int unsigned     stall_request;
    int unsigned     beats_sent;
    int unsigned     settings_applied;

    rail_monitor_ema_overcurrent_trip i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rail1_volts (sample_beat.level[0]),
        .rail1_amps  (sample_beat.level[1]),
        .rail2_volts (sample_beat.level[2]),
        .rail2_amps  (sample_beat.level[3]),
        .rail3_volts (sample_beat.level[4]),
        .rail3_amps  (sample_beat.level[5]),
        .rail4_volts (sample_beat.level[6]),
        .rail4_amps  (sample_beat.level[7]),
        .rail5_volts (sample_beat.level[8]),
        .rail5_amps  (sample_beat.level[9]),
        .temp_sample (sample_beat.level[10]),
        .enable_in   (sample_beat.enables),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .enable_out  (result_beat.enables),
        .avg1_volts  (result_beat.level[0]),
        .avg1_amps   (result_beat.level[1]),
        .avg2_volts  (result_beat.level[2]),
        .avg2_amps   (result_beat.level[3]),
        .avg3_volts  (result_beat.level[4]),
        .avg3_amps   (result_beat.level[5]),
        .avg4_volts  (result_beat.level[6]),
        .avg4_amps   (result_beat.level[7]),
        .avg5_volts  (result_beat.level[8]),
        .avg5_amps   (result_beat.level[9]),
        .avg_temp    (result_beat.level[10]),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $error("timeout: %0d beats still expected", sb.expected_averages.size());
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, a quiet mode, and a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_request != 0)
            begin
                hold_left = stall_request;
                stall_request = 0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_beat);
    end

    function automatic logic [SAMPLE_W-1:0] near(longint center);
        longint v;
        v = center + longint'($urandom_range(0, 2)) - 1;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    function automatic sample_set_t uniform_set(logic [SAMPLE_W-1:0] volts,
                                                logic [SAMPLE_W-1:0] amps,
                                                logic [SAMPLE_W-1:0] temp,
                                                logic [RAIL_COUNT-1:0] enables);
        sample_set_t s;
        for (int r = 0; r < RAIL_COUNT; r++)
        begin
            s.level[2*r]   = volts;
            s.level[2*r+1] = amps;
        end
        s.level[SUM_COUNT-1] = temp;
        s.enables = enables;
        return s;
    endfunction

    // mix of full-range values, values around each limit and extremes
    function automatic sample_set_t random_sample();
        sample_set_t s;
        int unsigned volts;
        for (int r = 0; r < RAIL_COUNT; r++)
        begin
            volts = $urandom_range(1, SAMPLE_MAX);
            s.level[2*r] = SAMPLE_W'(volts);
            case ($urandom_range(0, 5))
                0: s.level[2*r+1] = SAMPLE_W'($urandom);
                1: s.level[2*r+1] = near(sb.amp_limit[r]);
                2: s.level[2*r+1] = near(sb.power_limit / volts);
                3:
                begin
                    s.level[2*r]   = $urandom_range(0, 1) ? '1 : '0;
                    s.level[2*r+1] = $urandom_range(0, 1) ? '1 : '0;
                end
                default: s.level[2*r+1] = SAMPLE_W'($urandom_range(0, 3000));
            endcase
        end
        s.level[SUM_COUNT-1] = SAMPLE_W'($urandom);
        s.enables = RAIL_COUNT'($urandom);
        return s;
    endfunction

    // call in sync with clk; returns once the beat is accepted, at times only after a random idle gap with in_valid low
    task automatic send_sample(input sample_set_t s);
        sample_beat <= s;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_sample(s);
        beats_sent++;
        if (!quiet && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic run_random(input int count);
        repeat (count) send_sample(random_sample());
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(index, data);
    endtask

    task automatic close_writes();
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic program_uniform(input logic [CFG_DATA_W-1:0] limit,
                                   input logic [CFG_DATA_W-1:0] power);
        for (int r = 0; r < RAIL_COUNT; r++)
            write_register(REG_LIMIT_ONE + CFG_INDEX_W'(r), limit);
        write_register(REG_POWER_LIMIT, power);
        close_writes();
    endtask

    // stop offering, wait for every pending average, then let the pipe empty
    task automatic settle();
        int n;
        n = 0;
        if (in_valid)
            in_valid <= 1'b0;
        while (sb.expected_averages.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        sample_set_t s;
        in_valid      = 1'b0;
        sample_beat   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        quiet         = 1'b0;
        stall_request = 0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // seed beat: currents straddle the seed offset
        s = uniform_set('0, '0, '1, '1);
        s.level[2] = '1;
        s.level[3] = 16'd99;
        s.level[4] = 16'd1;
        s.level[5] = 16'd100;
        s.level[6] = 16'h8000;
        s.level[7] = 16'd101;
        s.level[8] = 16'd12345;
        s.level[9] = '1;
        send_sample(s);
        // reset limits: power trip boundary sits at 9450 * 10000
        send_sample(uniform_set('0, '0, '0, '1));
        send_sample(uniform_set('1, '1, '1, '1));
        send_sample(uniform_set(16'd9450, 16'd10000, 16'd4321, '1));
        send_sample(uniform_set(16'd9450, 16'd10001, 16'd4321, '1));
        send_sample(uniform_set(16'd1, '1, 16'd7, '0));
        send_sample(uniform_set('0, '1, 16'd7, 5'b10101));
        settle();

        // per-rail current limits, power out of reach; spare indexes ignored
        write_register(REG_LIMIT_ONE, 32'd0);
        write_register(REG_LIMIT_TWO, 32'd1000);
        write_register(REG_LIMIT_THREE, 32'd65535);
        write_register(REG_LIMIT_FOUR, 32'd500);
        write_register(REG_LIMIT_FIVE, 32'hABCD_1234);
        write_register(REG_POWER_LIMIT, 32'hFFFF_FFFF);
        write_register(REG_SPARE_LO, 32'd0);
        write_register(REG_SPARE_HI, 32'd0);
        close_writes();
        s = uniform_set('1, '0, 16'd100, '1);
        s.level[3] = 16'd1000;
        s.level[5] = '1;
        s.level[7] = 16'd500;
        s.level[9] = 16'h1234;
        send_sample(s);
        s.level[1] = 16'd1;
        s.level[3] = 16'd1001;
        s.level[7] = 16'd501;
        s.level[9] = 16'h1235;
        send_sample(s);
        send_sample(uniform_set('1, '0, 16'd200, '1));
        settle();

        // zero power limit: any nonzero product trips
        program_uniform(32'h0000_FFFF, 32'd0);
        send_sample(uniform_set('0, '1, '0, '1));
        send_sample(uniform_set(16'd1, 16'd1, '1, '1));
        send_sample(uniform_set('1, '0, 16'd55, 5'b01010));
        settle();

        // random limits, with one long output hold-off that backs up the input
        for (int r = 0; r < RAIL_COUNT; r++)
            write_register(REG_LIMIT_ONE + CFG_INDEX_W'(r), $urandom);
        write_register(REG_POWER_LIMIT, $urandom);
        close_writes();
        run_random(60);
        stall_request = HOLD_CYCLES;
        run_random(190);
        settle();

        program_uniform(32'd0, 32'd0);
        run_random(150);
        settle();

        // widest limits, no idling on either side
        program_uniform(32'h0000_FFFF, 32'hFFFF_FFFF);
        quiet = 1'b1;
        run_random(230);
        settle();
        quiet = 1'b0;

        for (int r = 0; r < RAIL_COUNT; r++)
            write_register(REG_LIMIT_ONE + CFG_INDEX_W'(r), $urandom_range(1000, 60000));
        write_register(REG_POWER_LIMIT, $urandom_range(1_000_000, 500_000_000));
        close_writes();
        run_random(250);
        settle();

        if (sb.expected_averages.size() != 0)
            sb.report($sformatf("%0d expected beats never arrived",
                                sb.expected_averages.size()));
        $display("Run covered %0d sample beats and %0d average beats over %0d limit settings",
                 beats_sent, sb.averages_checked, settings_applied);
        $display("Predicted rail trips: %0d; output held off once for %0d cycles",
                 sb.trip_events, HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
